@@ rtl/core/fssf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssf_pkg: shared types and constants of the splat film unit
// Word layouts, pixel store entry, register indexes and arithmetic widths.
// ----------------------------------------------------------------------------
package fssf_pkg;

  // parameter defaults
  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_MAX_HEIGHT    = 1024;
  localparam int DEF_TABLE_SIDE    = 16;
  localparam int DEF_FILTER_RADIUS = 2;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_CFG_W  = 11;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_INTERVAL = 2'd2;
  localparam logic [DIM_CFG_W-1:0]  RST_IMAGE_WIDTH    = 11'd1024;
  localparam logic [DIM_CFG_W-1:0]  RST_IMAGE_HEIGHT   = 11'd1024;
  localparam logic [15:0]           RST_WRITE_INTERVAL = 16'd1024;

  // actions
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_SPLAT   = 2'd1;
  localparam logic [1:0] ACT_RESOLVE = 2'd2;

  // arithmetic widths
  localparam int ACC_W   = 48;
  localparam int WT_W    = 32;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 33;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [WT_W-1:0]  WT_MAX  = {1'b0, {(WT_W-1){1'b1}}};
  localparam logic signed [WT_W-1:0]  WT_MIN  = {1'b1, {(WT_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]         action;
    logic [17:0]        sample_x;
    logic [17:0]        sample_y;
    logic [31:0]        color_red;
    logic [31:0]        color_green;
    logic [31:0]        color_blue;
    logic [7:0]         table_index;
    logic signed [15:0] table_weight;
    logic [19:0]        pixel_index;
    logic [15:0]        iteration;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_red;
    logic [31:0] out_green;
    logic [31:0] out_blue;
    logic        pixel_updated;
    logic        resolve_due;
  } out_word_t;

  // one pixel of the film store
  typedef struct packed {
    logic signed [ACC_W-1:0] acc_red;
    logic signed [ACC_W-1:0] acc_green;
    logic signed [ACC_W-1:0] acc_blue;
    logic signed [WT_W-1:0]  wt_sum;
    logic [31:0]             hist_red;
    logic [31:0]             hist_green;
    logic [31:0]             hist_blue;
  } pix_ent_t;

endpackage

@@ rtl/core/fssf_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssf_mul: shared registered multiplier
// Signed 34 x 17 product, registered.
// ----------------------------------------------------------------------------
module fssf_mul import fssf_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [MUL_P_W-1:0] mul_p
);

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

@@ rtl/core/fssf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssf_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit a cycle, truncating.
// ----------------------------------------------------------------------------
module fssf_div import fssf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      div_start,
  input  logic signed [DIV_N_W-1:0] div_num,
  input  logic signed [DIV_D_W-1:0] div_den,
  output logic                      div_done,
  output logic signed [DIV_N_W-1:0] div_quo
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] den_r;
  logic               neg_r;

  logic [DIV_N_W-1:0] num_mag;
  logic [DIV_D_W-1:0] den_mag;
  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W+1:0] trial;
  logic               q_bit;
  logic [DIV_D_W-1:0] rem_nxt;

  assign num_mag = div_num[DIV_N_W-1] ? unsigned'(-div_num) : unsigned'(div_num);
  assign den_mag = div_den[DIV_D_W-1] ? unsigned'(-div_den) : unsigned'(div_den);

  assign shifted = {rem_r, quo_r[DIV_N_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign q_bit   = ~trial[DIV_D_W+1];
  assign rem_nxt = q_bit ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      rem_r <= '0;
      quo_r <= num_mag;
      den_r <= den_mag;
      neg_r <= div_num[DIV_N_W-1] ^ div_den[DIV_D_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_N_W-2:0], q_bit};
    end
  end

  assign div_done = done_r;
  assign div_quo  = neg_r ? -signed'(quo_r) : signed'(quo_r);

endmodule

@@ rtl/core/filtered_sample_splat_film_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_sample_splat_film_unit: filter table splatting film accumulator
// Loads filter weights, splats color samples over a clipped footprint and
// resolves pixels into a progressive history.
// ----------------------------------------------------------------------------
//
//  port group | dir | handshake        | content
//  -----------+-----+------------------+-----------------------------------
//  in_*       | in  | in_valid/in_stall| action, sample, color, table, pixel
//  out_*      | out | out_valid/out_stall| history, pixel_updated, resolve_due
//  cfg_*      | in  | cfg_we           | image_width, image_height, interval
//
//  A load or an unused action goes straight to S_FIN. A splat walks its
//  clipped footprint (up to 5x5 pixels), each pixel
//  a store read, three passes through the shared multiplier and a write back.
//  A resolve of a pixel with a nonzero weight sum does, per color, two
//  64-step divisions in the shared divider plus one multiply.
//  After reset a clearing pass zeroes the pixel store and filter table
//  over max(MAX_WIDTH*MAX_HEIGHT, TABLE_SIDE^2) entries (1048576 by default),
//  with in_stall high; configuration writes are taken throughout.
//  One word is worked on at a time; a finished result waits in the output
//  register while the next input word is taken.
// ----------------------------------------------------------------------------
module filtered_sample_splat_film_unit import fssf_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int TABLE_SIDE    = DEF_TABLE_SIDE,
  parameter int FILTER_RADIUS = DEF_FILTER_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int PA_W      = $clog2(PIX_DEPTH);
  localparam int TAB_DEPTH = TABLE_SIDE * TABLE_SIDE;
  localparam int TA_W      = $clog2(TAB_DEPTH);
  localparam int TI_W      = $clog2(TABLE_SIDE);
  localparam int CLR_DEPTH = (PIX_DEPTH > TAB_DEPTH) ? PIX_DEPTH : TAB_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
  localparam int XW        = $clog2(MAX_WIDTH + 1);
  localparam int YW        = $clog2(MAX_HEIGHT + 1);
  localparam int DX_W      = 19;           // sample position less one half, Q.8
  localparam int SPAN_W    = 21;
  localparam int CRD_W     = 14;           // signed pixel coordinate
  localparam int DF_W      = CRD_W + 9;
  localparam int SC_W      = DF_W + TI_W + 1;
  localparam int CB_W      = MUL_P_W - 14;
  localparam int R_Q8      = FILTER_RADIUS * 256;

  localparam logic [1:0] C_RED   = 2'd0;
  localparam logic [1:0] C_GREEN = 2'd1;
  localparam logic [1:0] C_BLUE  = 2'd2;

  typedef enum logic [18:0] {
    S_CLEAR   = 19'h00001,
    S_IDLE    = 19'h00002,
    S_SPL_SET = 19'h00004,
    S_SPL_ROW = 19'h00008,
    S_SPL_BAS = 19'h00010,
    S_SPL_RD  = 19'h00020,
    S_SPL_LD  = 19'h00040,
    S_SPL_MUL = 19'h00080,
    S_SPL_ACC = 19'h00100,
    S_SPL_WR  = 19'h00200,
    S_RES_CHK = 19'h00400,
    S_RES_CMP = 19'h00800,
    S_RES_D1  = 19'h01000,
    S_RES_D1W = 19'h02000,
    S_RES_HM  = 19'h04000,
    S_RES_D2  = 19'h08000,
    S_RES_D2W = 19'h10000,
    S_RES_WR  = 19'h20000,
    S_FIN     = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [DIM_CFG_W-1:0] width_r;
  logic [DIM_CFG_W-1:0] height_r;
  logic [15:0]          interval_r;
  logic [XW-1:0]        w_c;
  logic [YW-1:0]        h_c;

  // control and working registers
  logic [CLR_W-1:0]        clr_r;
  logic [15:0]             smp_cnt_r;
  in_word_t                in_r;
  out_word_t               res_r;
  out_word_t               out_data_r;
  logic                    out_valid_r;
  pix_ent_t                ent_r;
  logic [1:0]              c_r;
  logic                    upd_r;
  logic signed [15:0]      wgt_r;
  logic signed [DIV_N_W-1:0] mean_r;
  logic signed [DX_W-1:0]  dx_r, dy_r;
  logic signed [CRD_W-1:0] x0_r, x1_r, y1_r, x_r, y_r, y0_r;
  logic [PA_W-1:0]         row_r;

  // memories
  pix_ent_t           pix_mem [PIX_DEPTH];
  pix_ent_t           pix_rdata_r;
  logic               pix_we;
  logic [PA_W-1:0]    pix_wa, pix_ra;
  pix_ent_t           pix_wd;
  logic signed [15:0] tab_mem [TAB_DEPTH];
  logic signed [15:0] tab_rdata_r;
  logic               tab_we;
  logic [TA_W-1:0]    tab_wa, tab_ra;
  logic signed [15:0] tab_wd;

  // shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      div_start;
  logic signed [DIV_N_W-1:0] div_num;
  logic signed [DIV_D_W-1:0] div_den;
  logic                      div_done;
  logic signed [DIV_N_W-1:0] div_quo;

  // footprint and per-pixel datapath
  logic signed [DX_W-1:0]   dx, dy;
  logic signed [SPAN_W-1:0] xlo, xhi, ylo, yhi;
  logic signed [CRD_W-1:0]  x0, x1, y0, y1, x0c, x1c, y0c, y1c, wm1, hm1;
  logic                     foot_empty;
  logic [TI_W-1:0]          ix, iy;
  logic [PA_W-1:0]          pa_spl;
  logic [31:0]              col_sel, hist_sel;
  logic signed [ACC_W-1:0]  acc_sel, acc_new;
  logic signed [CB_W-1:0]   contrib;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [WT_W:0]     wt_sum;
  logic signed [WT_W-1:0]   wt_new;
  logic [15:0]              cnt_inc;
  logic [31:0]              hist_new;
  logic                     accept;
  logic                     out_free;
  logic                     in_range;

  // quantized distance to a table index, clamped to the last entry
  function automatic logic [TI_W-1:0] dist_idx(input logic signed [CRD_W-1:0] pos,
                                               input logic signed [DX_W-1:0] d);
    logic signed [DF_W-1:0] df;
    logic [DF_W-1:0]        mag;
    logic [SC_W-1:0]        scl;
    logic [TI_W-1:0]        q;
    df  = (DF_W'(pos) <<< 8) - DF_W'(d);
    mag = df[DF_W-1] ? unsigned'(-df) : unsigned'(df);
    scl = SC_W'(mag) * SC_W'(TABLE_SIDE);
    q   = '0;
    for (int k = 1; k < TABLE_SIDE; k++) begin
      if (scl >= SC_W'(k * R_Q8)) q = q + TI_W'(1);
    end
    return q;
  endfunction

  fssf_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  fssf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo)
  );

  // -------- configuration --------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RST_IMAGE_WIDTH;
      height_r   <= RST_IMAGE_HEIGHT;
      interval_r <= RST_WRITE_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:    width_r    <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_IMAGE_HEIGHT:   height_r   <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_WRITE_INTERVAL: interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_r == '0) w_c = XW'(1);
    else if (16'(width_r) > 16'(MAX_WIDTH)) w_c = XW'(MAX_WIDTH);
    else w_c = XW'(width_r);
    if (height_r == '0) h_c = YW'(1);
    else if (16'(height_r) > 16'(MAX_HEIGHT)) h_c = YW'(MAX_HEIGHT);
    else h_c = YW'(height_r);
  end

  assign wm1 = CRD_W'(w_c) - CRD_W'(1);
  assign hm1 = CRD_W'(h_c) - CRD_W'(1);

  // -------- footprint of the held sample --------
  always_comb begin
    dx  = DX_W'($signed({1'b0, in_r.sample_x})) - DX_W'(128);
    dy  = DX_W'($signed({1'b0, in_r.sample_y})) - DX_W'(128);
    xlo = SPAN_W'(dx) - SPAN_W'(R_Q8);
    xhi = SPAN_W'(dx) + SPAN_W'(R_Q8);
    ylo = SPAN_W'(dy) - SPAN_W'(R_Q8);
    yhi = SPAN_W'(dy) + SPAN_W'(R_Q8);
    x0  = CRD_W'((xlo + SPAN_W'(255)) >>> 8);   // ceiling
    x1  = CRD_W'(xhi >>> 8);                    // floor
    y0  = CRD_W'((ylo + SPAN_W'(255)) >>> 8);
    y1  = CRD_W'(yhi >>> 8);
    x0c = (x0 < 0) ? CRD_W'(0) : x0;
    y0c = (y0 < 0) ? CRD_W'(0) : y0;
    x1c = (x1 > wm1) ? wm1 : x1;
    y1c = (y1 > hm1) ? hm1 : y1;
    foot_empty = (x1c < x0c) || (y1c < y0c);
  end

  assign ix     = dist_idx(x_r, dx_r);
  assign iy     = dist_idx(y_r, dy_r);
  assign pa_spl = row_r + PA_W'(unsigned'(x_r));

  // -------- per-color selection --------
  always_comb begin
    case (c_r)
      C_RED: begin
        col_sel  = in_r.color_red;
        acc_sel  = ent_r.acc_red;
        hist_sel = ent_r.hist_red;
      end
      C_GREEN: begin
        col_sel  = in_r.color_green;
        acc_sel  = ent_r.acc_green;
        hist_sel = ent_r.hist_green;
      end
      default: begin
        col_sel  = in_r.color_blue;
        acc_sel  = ent_r.acc_blue;
        hist_sel = ent_r.hist_blue;
      end
    endcase
  end

  // floor(color*weight / 2^14), then saturating accumulate
  assign contrib = CB_W'(mul_p >>> 14);
  assign acc_sum = (ACC_W+1)'(acc_sel) + (ACC_W+1)'(contrib);
  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) acc_new = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    else acc_new = acc_sum[ACC_W-1:0];
  end

  assign wt_sum = (WT_W+1)'(pix_rdata_r.wt_sum) + (WT_W+1)'(tab_rdata_r);
  always_comb begin
    if (wt_sum[WT_W] != wt_sum[WT_W-1]) wt_new = wt_sum[WT_W] ? WT_MIN : WT_MAX;
    else wt_new = wt_sum[WT_W-1:0];
  end

  // history clamps to [0, 2^32-1]
  always_comb begin
    if (div_quo[DIV_N_W-1]) hist_new = '0;
    else if (|div_quo[DIV_N_W-2:32]) hist_new = '1;
    else hist_new = div_quo[31:0];
  end

  assign cnt_inc  = smp_cnt_r + 16'd1;
  assign in_range = {{(MUL_P_W-20){1'b0}}, in_r.pixel_index} < unsigned'(mul_p);

  // -------- handshake --------
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------- sequencer --------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (clr_r == CLR_W'(CLR_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_SPLAT) state_nxt = S_SPL_SET;
          else if (in_data.action == ACT_RESOLVE) state_nxt = S_RES_CHK;
          else state_nxt = S_FIN;
        end
      end
      S_SPL_SET: state_nxt = foot_empty ? S_FIN : S_SPL_ROW;
      S_SPL_ROW: state_nxt = S_SPL_BAS;
      S_SPL_BAS: state_nxt = S_SPL_RD;
      S_SPL_RD:  state_nxt = S_SPL_LD;
      S_SPL_LD:  state_nxt = S_SPL_MUL;
      S_SPL_MUL: state_nxt = S_SPL_ACC;
      S_SPL_ACC: state_nxt = (c_r == C_BLUE) ? S_SPL_WR : S_SPL_MUL;
      S_SPL_WR:  state_nxt = (x_r == x1_r && y_r == y1_r) ? S_FIN : S_SPL_RD;
      S_RES_CHK: state_nxt = S_RES_CMP;
      S_RES_CMP: begin
        if (!in_range) state_nxt = S_FIN;
        else if (pix_rdata_r.wt_sum == '0) state_nxt = S_RES_WR;
        else state_nxt = S_RES_D1;
      end
      S_RES_D1:  state_nxt = S_RES_D1W;
      S_RES_D1W: if (div_done) state_nxt = S_RES_HM;
      S_RES_HM:  state_nxt = S_RES_D2;
      S_RES_D2:  state_nxt = S_RES_D2W;
      S_RES_D2W: if (div_done) state_nxt = (c_r == C_BLUE) ? S_RES_WR : S_RES_D1;
      S_RES_WR:  state_nxt = S_FIN;
      S_FIN:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  // shared unit operands and memory ports
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    pix_we    = 1'b0;
    pix_wa    = pa_spl;
    pix_wd    = ent_r;
    pix_ra    = pa_spl;
    tab_we    = 1'b0;
    tab_wa    = TA_W'(in_data.table_index);
    tab_wd    = in_data.table_weight;
    tab_ra    = TA_W'(iy) * TA_W'(TABLE_SIDE) + TA_W'(ix);
    unique case (state_r)
      S_CLEAR: begin
        pix_we = (clr_r < CLR_W'(PIX_DEPTH));
        pix_wa = clr_r[PA_W-1:0];
        pix_wd = '0;
        tab_we = (clr_r < CLR_W'(TAB_DEPTH));
        tab_wa = clr_r[TA_W-1:0];
        tab_wd = '0;
      end
      S_IDLE: begin
        // out-of-range table index is dropped
        tab_we = accept && (in_data.action == ACT_LOAD) &&
                 (16'(in_data.table_index) < 16'(TAB_DEPTH));
      end
      S_SPL_ROW: begin
        mul_a = MUL_A_W'(y0_r);
        mul_b = MUL_B_W'(w_c);
      end
      S_SPL_MUL: begin
        mul_a = MUL_A_W'(col_sel);
        mul_b = MUL_B_W'(wgt_r);
      end
      S_SPL_WR: pix_we = 1'b1;
      S_RES_CHK: begin
        mul_a  = MUL_A_W'(w_c);
        mul_b  = MUL_B_W'(h_c);
        pix_ra = PA_W'(in_r.pixel_index);
      end
      S_RES_D1: begin
        div_start = 1'b1;
        div_num   = DIV_N_W'(acc_sel) <<< 14;
        div_den   = DIV_D_W'(ent_r.wt_sum);
      end
      S_RES_HM: begin
        mul_a = MUL_A_W'(hist_sel);
        mul_b = MUL_B_W'(in_r.iteration);
      end
      S_RES_D2: begin
        div_start = 1'b1;
        div_num   = mean_r + DIV_N_W'(mul_p);
        div_den   = DIV_D_W'(in_r.iteration) + DIV_D_W'(1);
      end
      S_RES_WR: begin
        pix_we           = 1'b1;
        pix_wa           = PA_W'(in_r.pixel_index);
        pix_wd.acc_red   = '0;
        pix_wd.acc_green = '0;
        pix_wd.acc_blue  = '0;
        pix_wd.wt_sum    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_wa] <= pix_wd;
    pix_rdata_r <= pix_mem[pix_ra];
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_rdata_r <= tab_mem[tab_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      smp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      c_r         <= C_RED;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + CLR_W'(1);
      if (state_r == S_SPL_LD || state_r == S_RES_CMP) c_r <= C_RED;
      if ((state_r == S_SPL_ACC || (state_r == S_RES_D2W && div_done)) && c_r != C_BLUE)
        c_r <= c_r + 2'd1;
      // count the sample once its last footprint pixel is written; an empty footprint is not counted
      if (state_r == S_SPL_WR && x_r == x1_r && y_r == y1_r)
        smp_cnt_r <= (cnt_inc == interval_r) ? 16'd0 : cnt_inc;
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // working data
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r  <= in_data;
      res_r <= '0;
    end
    if (state_r == S_FIN && out_free) out_data_r <= res_r;
    unique case (state_r)
      S_SPL_SET: begin
        dx_r <= dx;
        dy_r <= dy;
        x0_r <= x0c;
        x1_r <= x1c;
        y0_r <= y0c;
        y1_r <= y1c;
        x_r  <= x0c;
        y_r  <= y0c;
      end
      S_SPL_BAS: row_r <= PA_W'(unsigned'(mul_p));
      S_SPL_LD: begin
        // store entry with the table weight already summed in
        ent_r <= '{acc_red:    pix_rdata_r.acc_red,
                   acc_green:  pix_rdata_r.acc_green,
                   acc_blue:   pix_rdata_r.acc_blue,
                   wt_sum:     wt_new,
                   hist_red:   pix_rdata_r.hist_red,
                   hist_green: pix_rdata_r.hist_green,
                   hist_blue:  pix_rdata_r.hist_blue};
        wgt_r <= tab_rdata_r;
      end
      S_SPL_ACC: begin
        case (c_r)
          C_RED:   ent_r.acc_red   <= acc_new;
          C_GREEN: ent_r.acc_green <= acc_new;
          default: ent_r.acc_blue  <= acc_new;
        endcase
      end
      S_SPL_WR: begin
        if (x_r == x1_r) begin
          x_r <= x0_r;
          if (y_r == y1_r) begin
            res_r.resolve_due <= (cnt_inc == interval_r);
          end else begin
            y_r   <= y_r + CRD_W'(1);
            row_r <= row_r + PA_W'(w_c);
          end
        end else begin
          x_r <= x_r + CRD_W'(1);
        end
      end
      S_RES_CMP: begin
        ent_r <= pix_rdata_r;
        upd_r <= (pix_rdata_r.wt_sum != '0);
      end
      S_RES_D1W: if (div_done) mean_r <= div_quo;
      S_RES_D2W: begin
        if (div_done) begin
          case (c_r)
            C_RED:   ent_r.hist_red   <= hist_new;
            C_GREEN: ent_r.hist_green <= hist_new;
            default: ent_r.hist_blue  <= hist_new;
          endcase
        end
      end
      S_RES_WR: begin
        res_r.out_red       <= ent_r.hist_red;
        res_r.out_green     <= ent_r.hist_green;
        res_r.out_blue      <= ent_r.hist_blue;
        res_r.pixel_updated <= upd_r;
      end
      default: ;
    endcase
  end

  // -------- assertions --------
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.pixel_updated && out_data.resolve_due))
    else $error("resolve and splat flags together");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_RES_D1W || state_r == S_RES_D2W))
    else $error("divider finished outside a wait state");

  a_foot_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPL_RD) |-> (x_r >= x0_r && x_r <= x1_r && y_r <= y1_r))
    else $error("footprint walk out of bounds");

endmodule
